/* hdl/lmbr_pkg.sv */
// Shared types, constants and helpers for the local map box recentering block.
`default_nettype none

package lmbr_pkg;

    localparam int MAX_AXES = 3;
    localparam int AXES_DEF = 3;
    localparam int COORD_W  = 32;
    localparam int IN_DW    = MAX_AXES * COORD_W;
    localparam int OUT_DW   = 2 * MAX_AXES * COORD_W;
    localparam int KIND_W   = 2;

    localparam int CUBE_W  = 20;
    localparam int DET_W   = 20;
    localparam int THR_W   = 11;
    localparam int HALF_W  = CUBE_W - 1;
    localparam int TPROD_W = 31;
    localparam int TF_W    = TPROD_W - 8;
    localparam int T2A_W   = 33;
    localparam int DIFF_W  = 34;
    localparam int TERM_W  = 38;
    localparam int MOV_W   = 27;
    localparam int RECIP_W = 32;
    localparam int PROD_W  = MOV_W + RECIP_W;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam int SETTLE   = 5;
    localparam int SETTLE_W = 3;

    localparam logic [CUBE_W-1:0] CUBE_RST = 20'd204800;
    localparam logic [DET_W-1:0]  DET_RST  = 20'd102400;
    localparam logic [THR_W-1:0]  THR_RST  = 11'd384;

    localparam int                 THR_ONE     = 256;
    localparam int                 SCALE_SH    = 10;
    localparam logic [RECIP_W-1:0] DIV5_RECIP  = 32'hCCCC_CCCD;
    localparam int                 DIV5_SHIFT  = 34;
    localparam int                 DIV5_BIAS_Q = 1 << 21;
    localparam int                 DIV5_BIAS   = 5 * DIV5_BIAS_Q;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT   = 2'd0,
        KIND_SAME   = 2'd1,
        KIND_MOVED  = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_CUBE = 2'd0,
        REG_DET  = 2'd1,
        REG_THR  = 2'd2
    } reg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [HALF_W-1:0]       half;
        logic [TF_W-1:0]         tf;
        logic signed [MOV_W-1:0] mov;
    } geom_t;

    typedef struct packed {
        logic   hit;
        logic   dir_low;
        coord_t nlo;
        coord_t nhi;
    } lane_res_t;

    function automatic coord_t sat32(input logic signed [COORD_W+1:0] v);
        coord_t r;
        if (v[COORD_W+1:COORD_W-1] == 3'b000 || v[COORD_W+1:COORD_W-1] == 3'b111) begin
            r = v[COORD_W-1:0];
        end else if (v[COORD_W+1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/lmbr_cfg.sv */
// Register file and derived trigger and move distances.
`default_nettype none

module lmbr_cfg import lmbr_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output geom_t                  geom,
    output logic                   settled
);

    logic [CUBE_W-1:0]   cube_reg;
    logic [DET_W-1:0]    det_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [SETTLE_W-1:0] settle_reg, settle_next;
    logic                wr_en;
    logic [1:0]          reg_sel;

    logic [TPROD_W-1:0]       thr_x, det_x, tprod_reg;
    logic signed [T2A_W-1:0]  det_s, thm_s, t2a_reg;
    logic signed [DIFF_W-1:0] diff;
    logic signed [TERM_W-1:0] d38, a38, t1_next, t2_next, t1_reg, t2_reg;
    logic signed [TERM_W-1:0] mx, q;
    logic [MOV_W-1:0]         u_next, u_reg, quo;
    logic [PROD_W-1:0]        u_x, r_x, prod_reg;
    logic signed [MOV_W-1:0]  mov_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[APB_AW-1:2];

    always_comb begin
        settle_next = settle_reg;
        if (wr_en) begin
            settle_next = SETTLE_W'(SETTLE);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cube_reg   <= CUBE_RST;
            det_reg    <= DET_RST;
            thr_reg    <= THR_RST;
            settle_reg <= SETTLE_W'(SETTLE);
        end else begin
            settle_reg <= settle_next;
            if (wr_en) begin
                unique case (reg_sel)
                    REG_CUBE: cube_reg <= pwdata[CUBE_W-1:0];
                    REG_DET:  det_reg  <= pwdata[DET_W-1:0];
                    REG_THR:  thr_reg  <= pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CUBE: prdata = APB_DW'(cube_reg);
            REG_DET:  prdata = APB_DW'(det_reg);
            REG_THR:  prdata = APB_DW'(thr_reg);
            default:  prdata = '0;
        endcase
    end

    assign settled = (settle_reg == '0);

    assign thr_x = TPROD_W'(thr_reg);
    assign det_x = TPROD_W'(det_reg);
    assign det_s = signed'(T2A_W'(det_reg));
    assign thm_s = signed'(T2A_W'(thr_reg)) - signed'(T2A_W'(THR_ONE));

    assign diff    = signed'(DIFF_W'({cube_reg, 8'b0})) - signed'(DIFF_W'({tprod_reg, 1'b0}));
    assign d38     = TERM_W'(diff);
    assign a38     = TERM_W'(t2a_reg);
    assign t1_next = (d38 <<< 3) + d38;
    assign t2_next = (a38 <<< 4) + (a38 <<< 2);

    assign mx     = (t1_reg > t2_reg) ? t1_reg : t2_reg;
    assign q      = mx >>> SCALE_SH;
    assign u_next = q[MOV_W-1:0] + MOV_W'(DIV5_BIAS);

    assign u_x = PROD_W'(u_reg);
    assign r_x = PROD_W'(DIV5_RECIP);
    assign quo = MOV_W'(prod_reg >> DIV5_SHIFT);

    always_ff @(posedge aclk) begin
        tprod_reg <= thr_x * det_x;
        t2a_reg   <= det_s * thm_s;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        u_reg     <= u_next;
        prod_reg  <= u_x * r_x;
        mov_reg   <= signed'(quo - MOV_W'(DIV5_BIAS_Q));
    end

    assign geom.half = cube_reg[CUBE_W-1:1];
    assign geom.tf   = tprod_reg[TPROD_W-1:8];
    assign geom.mov  = mov_reg;

endmodule

`default_nettype wire

/* hdl/lmbr_lane.sv */
// One axis lane: face trigger test and next corner values.
`default_nettype none

module lmbr_lane import lmbr_pkg::*; (
    input  coord_t    pos,
    input  coord_t    box_lo,
    input  coord_t    box_hi,
    input  wire logic box_ready,
    input  geom_t     geom,
    output lane_res_t res
);

    localparam int W = COORD_W + 2;

    logic signed [W-1:0] pos_w, lo_w, hi_w, tf_w, half_w, mov_w, d_lo, d_hi;
    logic                hit_lo, hit_hi;

    assign pos_w  = W'(pos);
    assign lo_w   = W'(box_lo);
    assign hi_w   = W'(box_hi);
    assign tf_w   = signed'(W'(geom.tf));
    assign half_w = signed'(W'(geom.half));
    assign mov_w  = W'(signed'(geom.mov));

    assign d_lo   = pos_w - lo_w;
    assign d_hi   = pos_w - hi_w;
    assign hit_lo = (d_lo <= tf_w) && (d_lo >= -tf_w);
    assign hit_hi = (d_hi <= tf_w) && (d_hi >= -tf_w);

    always_comb begin
        res.hit     = box_ready && (hit_lo || hit_hi);
        res.dir_low = hit_lo;
        priority if (!box_ready) begin
            res.nlo = sat32(pos_w - half_w);
            res.nhi = sat32(pos_w + half_w);
        end else if (hit_lo) begin
            res.nlo = sat32(lo_w - mov_w);
            res.nhi = sat32(hi_w - mov_w);
        end else if (hit_hi) begin
            res.nlo = sat32(lo_w + mov_w);
            res.nhi = sat32(hi_w + mov_w);
        end else begin
            res.nlo = box_lo;
            res.nhi = box_hi;
        end
    end

endmodule

`default_nettype wire

/* hdl/lmbr_emit.sv */
// Merge of lane results into a request record and result sequencer.
`default_nettype none

module lmbr_emit import lmbr_pkg::*; #(
    parameter int AXES = AXES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic              box_ready,
    input  coord_t                 old_lo [AXES],
    input  coord_t                 old_hi [AXES],
    input  lane_res_t              lanes  [AXES],
    output logic                   rec_free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_DW-1:0] m_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z
    output logic      [KIND_W-1:0] m_tuser,  // kind
    output logic                   m_tlast
);

    logic            rec_valid_reg, rec_valid_next;
    kind_t           rec_kind_reg;
    logic [AXES-1:0] rec_pend_reg, rec_dir_reg;
    coord_t          rec_olo_reg [AXES];
    coord_t          rec_ohi_reg [AXES];
    coord_t          rec_nlo_reg [AXES];
    coord_t          rec_nhi_reg [AXES];

    logic            m_tvalid_reg, m_tvalid_next;
    kind_t           m_kind_reg;
    logic            m_last_reg;
    coord_t          m_lo_reg [AXES];
    coord_t          m_hi_reg [AXES];

    logic            out_load, last_now, rec_done;
    logic [AXES-1:0] sel_oh, hits, dirs;
    coord_t          rem_lo [AXES];
    coord_t          rem_hi [AXES];
    kind_t           load_kind;

    assign out_load = rec_valid_reg && (!m_tvalid_reg || m_tready);
    assign last_now = (rec_pend_reg == '0);
    assign rec_done = out_load && last_now;
    assign rec_free = !rec_valid_reg || rec_done;
    assign sel_oh   = rec_pend_reg & (~rec_pend_reg + AXES'(1));

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            hits[a]   = lanes[a].hit;
            dirs[a]   = lanes[a].dir_low;
            rem_lo[a] = (sel_oh[a] && rec_dir_reg[a]) ? rec_nhi_reg[a] : rec_olo_reg[a];
            rem_hi[a] = (sel_oh[a] && !rec_dir_reg[a]) ? rec_nlo_reg[a] : rec_ohi_reg[a];
        end
        priority if (!box_ready) begin
            load_kind = KIND_INIT;
        end else if (hits != '0) begin
            load_kind = KIND_MOVED;
        end else begin
            load_kind = KIND_SAME;
        end
    end

    always_comb begin
        rec_valid_next = rec_valid_reg;
        if (load) begin
            rec_valid_next = 1'b1;
        end else if (rec_done) begin
            rec_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            rec_valid_reg <= rec_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_kind_reg <= load_kind;
            rec_pend_reg <= hits;
            rec_dir_reg  <= dirs;
            for (int a = 0; a < AXES; a++) begin
                rec_olo_reg[a] <= old_lo[a];
                rec_ohi_reg[a] <= old_hi[a];
                rec_nlo_reg[a] <= lanes[a].nlo;
                rec_nhi_reg[a] <= lanes[a].nhi;
            end
        end else if (out_load && !last_now) begin
            rec_pend_reg <= rec_pend_reg & ~sel_oh;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (last_now) begin
                m_kind_reg <= rec_kind_reg;
                m_last_reg <= 1'b1;
                m_lo_reg   <= rec_nlo_reg;
                m_hi_reg   <= rec_nhi_reg;
            end else begin
                m_kind_reg <= KIND_REMOVE;
                m_last_reg <= 1'b0;
                m_lo_reg   <= rem_lo;
                m_hi_reg   <= rem_hi;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    for (genvar a = 0; a < MAX_AXES; a++) begin : g_pack
        if (a < AXES) begin : g_on
            assign m_tdata[a*COORD_W +: COORD_W]            = m_lo_reg[a];
            assign m_tdata[(a+MAX_AXES)*COORD_W +: COORD_W] = m_hi_reg[a];
        end else begin : g_off
            assign m_tdata[a*COORD_W +: COORD_W]            = '0;
            assign m_tdata[(a+MAX_AXES)*COORD_W +: COORD_W] = '0;
        end
    end

endmodule

`default_nettype wire

/* hdl/local_map_box_recentering.sv */
// Top level of the local map box recentering block.
//
// Slave stream s_*: one sensor position per request, tdata = pos_x, pos_y, pos_z.
// Master stream m_*: result boxes, tuser = kind, tdata = min and max corners,
// tlast on the final result of a position. APB port: cube edge length at 0x0,
// detection_range at 0x4, move_threshold at 0x8.
// The first position after reset centers the cube and yields one result.
// Later positions yield one result, or one removal box per shifted axis
// followed by the moved box.
// A position passes the input register, the request record and the output
// register before its first result appears. Throughput: one result per cycle
// while m_tready is high, through the single output register; an unchanged box
// allows one position per cycle while m_tready is high. Each position sees the
// box left by the one before it. After reset and after each register write,
// s_tready stays low until the move distance is recomputed by its pipeline.
// When m_tready is low, the output register holds, one request waits in the
// record and one in the input register; then s_tready drops.
`default_nettype none

module local_map_box_recentering import lmbr_pkg::*; #(
    parameter int AXES = AXES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,  // pos_x, pos_y, pos_z
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_DW-1:0] m_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z
    output logic      [KIND_W-1:0] m_tuser,  // kind
    output logic                   m_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    geom_t     geom;
    logic      settled;
    logic      in_valid_reg, in_valid_next;
    logic      s_accept, in_fire, rec_free;
    logic      box_ready_reg;
    coord_t    pos_reg    [AXES];
    coord_t    box_lo_reg [AXES];
    coord_t    box_hi_reg [AXES];
    lane_res_t lanes      [AXES];
    logic      cfg_wr;

    lmbr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom),
        .settled (settled)
    );

    assign in_fire  = in_valid_reg && rec_free;
    assign s_tready = settled && (!in_valid_reg || in_fire);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            box_ready_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= '0;
            end
        end else begin
            in_valid_reg <= in_valid_next;
            if (in_fire) begin
                box_ready_reg <= 1'b1;
                for (int a = 0; a < AXES; a++) begin
                    box_lo_reg[a] <= lanes[a].nlo;
                    box_hi_reg[a] <= lanes[a].nhi;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int a = 0; a < AXES; a++) begin
                pos_reg[a] <= s_tdata[a*COORD_W +: COORD_W];
            end
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        lmbr_lane u_lane (
            .pos       (pos_reg[a]),
            .box_lo    (box_lo_reg[a]),
            .box_hi    (box_hi_reg[a]),
            .box_ready (box_ready_reg),
            .geom      (geom),
            .res       (lanes[a])
        );
    end

    lmbr_emit #(
        .AXES (AXES)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_fire),
        .box_ready (box_ready_reg),
        .old_lo    (box_lo_reg),
        .old_hi    (box_hi_reg),
        .lanes     (lanes),
        .rec_free  (rec_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign cfg_wr = psel & penable & pwrite;

    a_cfg_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_tready)
        else $error("request accepted right after a register write");

    a_remove_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_REMOVE) |-> !m_tlast)
        else $error("removal box marked as final result");

    a_init_first: assert property (@(posedge aclk) disable iff (!aresetn)
        !box_ready_reg |-> !(m_tvalid && (m_tuser == KIND_SAME || m_tuser == KIND_MOVED)))
        else $error("box result before the box was initialized");

endmodule

`default_nettype wire
